FILE: src/tgst_pkg.sv
// Package for the two-gate speed trap timer.
// Holds field widths, reset values, register indexes, state codes and payload types.
// No dependencies.
package tgst_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_W     = 16;
  localparam int DIST_W      = 20;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SAMPLE_BITS-1:0] THRESH_RST  = SAMPLE_BITS'(150);
  localparam logic [COUNT_W-1:0]     TIMEOUT_RST = COUNT_W'(4000);
  localparam logic [DIST_W-1:0]      DIST_RST    = DIST_W'(50000);
  localparam logic [COUNT_W-1:0]     COUNT_MAX   = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_FACTOR = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] start_sample;
    logic [SAMPLE_BITS-1:0] stop_sample;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] elapsed_ms;
    logic [DIST_W-1:0]  speed_value;
    logic               timed_out;
  } out_item_t;

endpackage

FILE: src/two_gate_speed_trap_timer_unit.sv
// Top level of the two-gate speed trap timer: gate detection, run counter, sequencer, output register.
// Depends on tgst_pkg and tgst_div.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_item_t (start_sample, stop_sample)
//   out_     output     out_valid/out_stall out_item_t (elapsed_ms, speed_value, timed_out)
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A tick that yields no result is taken without a stall; the next can follow at once.
// A tick that ends a run is accepted and starts the divider; the sequencer then waits for its done
// flag and loads the result into the output register.
// The load waits while the output register holds an untaken result; in_stall stays high meanwhile.
// Reset is synchronous; afterwards the block is idle, config at reset values; out_data is not reset.
// cfg_ready is always high.
module two_gate_speed_trap_timer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tgst_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tgst_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tgst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgst_pkg::DIST_W-1:0]    cfg_data
);
  import tgst_pkg::*;

  state_t                 state_r, state_nxt;
  logic                   timing_r, timing_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   res_tmo_r, res_tmo_nxt;
  logic [SAMPLE_BITS-1:0] thr_r, thr_nxt;
  logic [COUNT_W-1:0]     tmo_r, tmo_nxt;
  logic [DIST_W-1:0]      dist_r, dist_nxt;
  out_item_t              out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   start_dark, stop_dark, expired;
  logic [COUNT_W-1:0]     cnt_inc;
  logic                   div_start, div_done;
  logic [DIST_W-1:0]      div_quo;

  assign start_dark = in_data.start_sample < thr_r;
  assign stop_dark  = in_data.stop_sample < thr_r;
  assign cnt_inc    = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_W'(1);
  assign expired    = cnt_inc >= tmo_r;

  tgst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dist_r),
    .divisor  (cnt_inc),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    timing_nxt    = timing_r;
    count_nxt     = count_r;
    res_tmo_nxt   = res_tmo_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    in_stall      = state_r != ST_WAIT;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_WAIT: begin
        if (in_valid) begin
          if (!timing_r) begin
            if (start_dark) begin
              timing_nxt = 1'b1;
              count_nxt  = '0;
            end
          end else begin
            count_nxt = cnt_inc;
            if (expired || stop_dark) begin
              timing_nxt  = 1'b0;
              res_tmo_nxt = expired;
              div_start   = 1'b1;
              state_nxt   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.elapsed_ms  = count_r;
          out_nxt.speed_value = res_tmo_r ? '0 : div_quo;
          out_nxt.timed_out   = res_tmo_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_WAIT;
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

  always_comb begin
    thr_nxt  = thr_r;
    tmo_nxt  = tmo_r;
    dist_nxt = dist_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DARK_THRESHOLD:  thr_nxt  = cfg_data[SAMPLE_BITS-1:0];
        CFG_TIMEOUT_MS:      tmo_nxt  = cfg_data[COUNT_W-1:0];
        CFG_DISTANCE_FACTOR: dist_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      timing_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      thr_r       <= THRESH_RST;
      tmo_r       <= TIMEOUT_RST;
      dist_r      <= DIST_RST;
    end else begin
      state_r     <= state_nxt;
      timing_r    <= timing_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
      tmo_r       <= tmo_nxt;
      dist_r      <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_tmo_r <= res_tmo_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  a_idle_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH |-> !timing_r) else $error("run still active at result load");
  a_timeout_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.timed_out |-> out_r.speed_value == '0)
    else $error("speed not zero on timeout");
  a_elapsed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.elapsed_ms != '0) else $error("zero elapsed time in result");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV) else $error("divider done outside divide state");

endmodule

FILE: src/tgst_div.sv
// Iterative restoring divider: distance factor over elapsed count, one quotient bit a cycle.
// Depends on tgst_pkg for operand widths.
module tgst_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tgst_pkg::DIST_W-1:0]  dividend,
  input  logic [tgst_pkg::COUNT_W-1:0] divisor,
  output logic                         done,
  output logic [tgst_pkg::DIST_W-1:0]  quotient
);
  import tgst_pkg::*;

  localparam int              CNT_W = $clog2(DIST_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIST_W - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] div_r, div_nxt;
  logic [DIST_W-1:0]  quo_r, quo_nxt;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               ge;

  assign trial = {rem_r, quo_r[DIST_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo_nxt = {quo_r[DIST_W-2:0], ge};
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divide started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divide done without a run");
  a_count_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> cnt_r == '0) else $error("divide step count not cleared");

endmodule
